// ----- design/stp_pkg.sv -----
`timescale 1ns / 1ps
package stp_pkg;

  localparam int unsigned ZW   = 27;
  localparam int unsigned AW   = 27;
  localparam int unsigned BW   = 7;
  localparam int unsigned GDW  = 41;
  localparam int unsigned GRW  = 49;
  localparam int unsigned NUW  = 41;
  localparam int unsigned MAGW = 42;
  localparam int unsigned QUW  = 15;
  localparam int unsigned DVS  = 15;
  localparam int unsigned GQW  = 8;
  localparam int unsigned GST  = DVS - GQW;

  typedef enum logic [2:0] {
    CFG_DEPTH_RATE   = 3'd0,
    CFG_FOCAL_LENGTH = 3'd1,
    CFG_CENTER_X     = 3'd2,
    CFG_CENTER_Y     = 3'd3,
    CFG_VIS_WIDTH    = 3'd4,
    CFG_VIS_HEIGHT   = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic [15:0] depth_rate;
    logic [11:0] focal_length;
    logic [11:0] center_x;
    logic [11:0] center_y;
    logic [12:0] vis_width;
    logic [12:0] vis_height;
  } cfg_t;

  typedef struct packed {
    logic signed [15:0] sx;
    logic signed [15:0] sy;
    logic [16:0]        nd;
    logic [ZW-1:0]      q0;
    logic [AW-1:0]      a;
    logic [BW-1:0]      b;
    logic [GDW-1:0]     gden;
  } star_t;

endpackage

// ----- design/stp_if.sv -----
`timescale 1ns / 1ps
interface stp_star_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] star_x;
  logic signed [15:0] star_y;
  logic [16:0]        star_depth;
  logic [15:0]        elapsed_ms;

  modport source (output valid, star_x, star_y, star_depth, elapsed_ms, input ready);
  modport sink (input valid, star_x, star_y, star_depth, elapsed_ms, output ready);
  modport monitor (input valid, ready, star_x, star_y, star_depth, elapsed_ms);
endinterface

interface stp_pix_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] pixel_u;
  logic signed [15:0] pixel_v;
  logic [7:0]         gray_level;
  logic               on_screen;
  logic [16:0]        new_depth;
  logic               last_point;

  modport source (output valid, pixel_u, pixel_v, gray_level, on_screen, new_depth,
                  last_point, input ready);
  modport sink (input valid, pixel_u, pixel_v, gray_level, on_screen, new_depth,
                last_point, output ready);
  modport monitor (input valid, ready, pixel_u, pixel_v, gray_level, on_screen,
                   new_depth, last_point);
endinterface

// ----- design/stp_front.sv -----
`timescale 1ns / 1ps
module stp_front #(
  parameter int unsigned TAIL_POINTS = 30
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  stp_pkg::cfg_t cfg_i,
  stp_star_if.sink      star_i,
  output stp_pkg::star_t item_o,
  output logic          push_o,
  input  logic          full_i
);

  localparam int unsigned     M     = TAIL_POINTS - 1;
  localparam int unsigned     KSH   = 27 + $clog2(M);
  localparam longint unsigned RCP   = ((64'd1 << KSH) + 64'(M) - 64'd1) / 64'(M);
  localparam logic [28:0]     RECIP = 29'(RCP);
  localparam logic [6:0]      MC    = 7'(M);
  localparam logic [8:0]      G5M   = 9'(5 * M);

  typedef enum logic [2:0] {F_IDLE, F_STEP, F_QUO, F_REM, F_PUSH} fstate_e;

  fstate_e            state_q;
  logic [31:0]        prod_q;
  logic signed [15:0] sx_q, sy_q;
  logic [15:0]        depth_q;
  logic [16:0]        nd_q;
  logic [26:0]        q0_q;
  logic [26:0]        quo_q;
  logic [6:0]         b_q;
  logic [33:0]        nd2_q;
  logic [40:0]        gden_q;

  logic        accept;
  logic [31:0] rnd;
  logic [23:0] step;
  logic [15:0] wrap;
  logic [55:0] qmul;
  logic [33:0] qm;
  logic [26:0] qrem;

  assign star_i.ready = (state_q == F_IDLE) || (state_q == F_PUSH && !full_i);
  assign accept = star_i.valid && star_i.ready;
  assign push_o = (state_q == F_PUSH) && !full_i;

  assign rnd  = prod_q + 32'd128;
  assign step = rnd[31:8];
  assign wrap = depth_q - 16'd1 - step[15:0];

  // quotient and remainder of five steps by the tail length minus one
  assign qmul = q0_q * RECIP;
  assign qm   = quo_q * MC;
  assign qrem = q0_q - qm[26:0];

  always_comb begin
    item_o.sx   = sx_q;
    item_o.sy   = sy_q;
    item_o.nd   = nd_q;
    item_o.q0   = q0_q;
    item_o.a    = quo_q;
    item_o.b    = b_q;
    item_o.gden = gden_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
    end else begin
      if (accept) begin
        prod_q  <= star_i.elapsed_ms * cfg_i.depth_rate;
        sx_q    <= star_i.star_x;
        sy_q    <= star_i.star_y;
        depth_q <= star_i.star_depth[15:0];
      end
      case (state_q)
        F_IDLE: begin
          if (accept) state_q <= F_STEP;
        end
        F_STEP: begin
          nd_q    <= {1'b0, wrap} + 17'd1;
          q0_q    <= 27'({step, 2'b00}) + 27'(step);
          state_q <= F_QUO;
        end
        F_QUO: begin
          quo_q   <= 27'(qmul >> KSH);
          nd2_q   <= nd_q * nd_q;
          state_q <= F_REM;
        end
        F_REM: begin
          b_q     <= {qrem[5:0], 1'b0};
          gden_q  <= 41'(nd2_q) * 41'(G5M);
          state_q <= F_PUSH;
        end
        F_PUSH: begin
          if (!full_i) state_q <= accept ? F_STEP : F_IDLE;
        end
        default: state_q <= F_IDLE;
      endcase
    end
  end

endmodule

// ----- design/stp_queue.sv -----
`timescale 1ns / 1ps
module stp_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  stp_pkg::star_t item_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           empty_o,
  output stp_pkg::star_t item_o
);

  stp_pkg::star_t mem_q [2];
  logic           wp_q, rp_q;
  logic [1:0]     cnt_q;

  assign full_o  = cnt_q == 2'd2;
  assign empty_o = cnt_q == 2'd0;
  assign item_o  = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wp_q] <= item_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) wp_q <= ~wp_q;
      if (pop_i) rp_q <= ~rp_q;
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop_i);
    end
  end

endmodule

// ----- design/stp_back.sv -----
`timescale 1ns / 1ps
module stp_back #(
  parameter int unsigned TAIL_POINTS = 30
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  stp_pkg::cfg_t  cfg_i,
  input  stp_pkg::star_t item_i,
  input  logic           empty_i,
  output logic           pop_o,
  stp_pix_if.source      pix_o
);

  localparam int unsigned M   = TAIL_POINTS - 1;
  localparam int unsigned JW  = $clog2(TAIL_POINTS);
  localparam int unsigned GJW = 8 + JW;
  localparam logic [7:0]  D2M = 8'(2 * M);

  typedef struct packed {
    logic signed [15:0]       sx;
    logic signed [15:0]       sy;
    logic [stp_pkg::ZW-1:0]   z;
    logic [16:0]              nd;
    logic [stp_pkg::GDW-1:0]  gden;
    logic [JW-1:0]            j;
    logic                     last;
  } s1_t;

  typedef struct packed {
    logic signed [28:0]       pu;
    logic signed [28:0]       pv;
    logic [38:0]              cu;
    logic [38:0]              cv;
    logic [GJW-1:0]           gj;
    logic [stp_pkg::ZW-1:0]   z;
    logic [16:0]              nd;
    logic [stp_pkg::GDW-1:0]  gden;
    logic                     last;
  } s2_t;

  typedef struct packed {
    logic                      sat_u;
    logic                      neg_u;
    logic [stp_pkg::MAGW-1:0]  rem_u;
    logic [stp_pkg::QUW-1:0]   q_u;
    logic                      sat_v;
    logic                      neg_v;
    logic [stp_pkg::MAGW-1:0]  rem_v;
    logic [stp_pkg::QUW-1:0]   q_v;
    logic [stp_pkg::ZW-1:0]    z;
    logic                      gsat;
    logic [stp_pkg::GRW-1:0]   grem;
    logic [stp_pkg::GQW-1:0]   gq;
    logic [stp_pkg::GDW-1:0]   gden;
    logic [16:0]               nd;
    logic                      last;
  } dv_t;

  logic                   adv;
  logic                   act_q;
  stp_pkg::star_t         cur_q;
  logic [JW-1:0]          j_q;
  logic [stp_pkg::ZW-1:0] q_q;
  logic [stp_pkg::BW-1:0] r_q;
  logic [7:0]             rdiff;
  logic                   emit;

  logic s1_vld_q, s2_vld_q, out_vld_q;
  s1_t  s1_q;
  s2_t  s2_q;
  logic dv_vld_q [stp_pkg::DVS+1];
  dv_t  dv_q [stp_pkg::DVS+1];

  logic signed [stp_pkg::NUW-1:0] nu, nv;
  logic [stp_pkg::NUW-1:0]        mu, mv;
  logic [stp_pkg::MAGW-1:0]       zlim;
  logic [stp_pkg::GRW-1:0]        gnum;

  logic signed [15:0] u_c, v_c;
  dv_t                fin;

  assign adv   = !out_vld_q || pix_o.ready;
  assign pop_o = !act_q && !empty_i;
  assign emit  = act_q && adv;
  assign rdiff = {1'b0, r_q} - {1'b0, cur_q.b};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q <= 1'b0;
    end else begin
      if (pop_o) begin
        act_q <= 1'b1;
        cur_q <= item_i;
        q_q   <= item_i.q0;
        r_q   <= stp_pkg::BW'(M);
        j_q   <= '0;
      end else if (emit) begin
        j_q <= j_q + 1'b1;
        if (rdiff[7]) begin
          r_q <= stp_pkg::BW'(rdiff + D2M);
          q_q <= q_q - cur_q.a - 1'b1;
        end else begin
          r_q <= rdiff[stp_pkg::BW-1:0];
          q_q <= q_q - cur_q.a;
        end
        if (j_q == JW'(M)) act_q <= 1'b0;
      end
    end
  end

  always_comb begin
    nu   = {{11{s2_q.pu[28]}}, s2_q.pu, 1'b0} + {2'b00, s2_q.cu};
    nv   = {{11{s2_q.pv[28]}}, s2_q.pv, 1'b0} + {2'b00, s2_q.cv};
    mu   = nu[stp_pkg::NUW-1] ? -nu : nu;
    mv   = nv[stp_pkg::NUW-1] ? -nv : nv;
    zlim = {s2_q.z, 15'b0};
    gnum = stp_pkg::GRW'({s2_q.gj, 32'b0});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q    <= 1'b0;
      s2_vld_q    <= 1'b0;
      dv_vld_q[0] <= 1'b0;
    end else if (adv) begin
      s1_vld_q    <= act_q;
      s2_vld_q    <= s1_vld_q;
      dv_vld_q[0] <= s2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_q.sx   <= cur_q.sx;
      s1_q.sy   <= cur_q.sy;
      s1_q.z    <= stp_pkg::ZW'(cur_q.nd) + q_q;
      s1_q.nd   <= cur_q.nd;
      s1_q.gden <= cur_q.gden;
      s1_q.j    <= j_q;
      s1_q.last <= j_q == JW'(M);

      s2_q.pu   <= $signed({1'b0, cfg_i.focal_length}) * s1_q.sx;
      s2_q.pv   <= $signed({1'b0, cfg_i.focal_length}) * s1_q.sy;
      s2_q.cu   <= cfg_i.center_x * s1_q.z;
      s2_q.cv   <= cfg_i.center_y * s1_q.z;
      s2_q.gj   <= 8'd255 * s1_q.j;
      s2_q.z    <= s1_q.z;
      s2_q.nd   <= s1_q.nd;
      s2_q.gden <= s1_q.gden;
      s2_q.last <= s1_q.last;

      dv_q[0].neg_u <= nu[stp_pkg::NUW-1];
      dv_q[0].neg_v <= nv[stp_pkg::NUW-1];
      dv_q[0].rem_u <= {1'b0, mu};
      dv_q[0].rem_v <= {1'b0, mv};
      dv_q[0].sat_u <= {1'b0, mu} >= zlim;
      dv_q[0].sat_v <= {1'b0, mv} >= zlim;
      dv_q[0].q_u   <= '0;
      dv_q[0].q_v   <= '0;
      dv_q[0].z     <= s2_q.z;
      dv_q[0].gsat  <= gnum >= {s2_q.gden, 8'b0};
      dv_q[0].grem  <= gnum;
      dv_q[0].gq    <= '0;
      dv_q[0].gden  <= s2_q.gden;
      dv_q[0].nd    <= s2_q.nd;
      dv_q[0].last  <= s2_q.last;
    end
  end

  for (genvar k = 0; k < stp_pkg::DVS; k++) begin : g_div
    localparam int unsigned SH = stp_pkg::DVS - 1 - k;
    logic [stp_pkg::MAGW-1:0] dsh;
    logic [stp_pkg::GRW-1:0]  gdsh;
    logic                     bu, bv, bg;
    dv_t                      nx;

    always_comb begin
      dsh  = {{(stp_pkg::MAGW - stp_pkg::ZW){1'b0}}, dv_q[k].z} << SH;
      gdsh = {{(stp_pkg::GRW - stp_pkg::GDW){1'b0}}, dv_q[k].gden} << (SH % stp_pkg::GQW);
      bu   = dv_q[k].rem_u >= dsh;
      bv   = dv_q[k].rem_v >= dsh;
      bg   = (k >= stp_pkg::GST) && (dv_q[k].grem >= gdsh);
      nx   = dv_q[k];
      nx.q_u = {dv_q[k].q_u[stp_pkg::QUW-2:0], bu};
      nx.q_v = {dv_q[k].q_v[stp_pkg::QUW-2:0], bv};
      if (bu) nx.rem_u = dv_q[k].rem_u - dsh;
      if (bv) nx.rem_v = dv_q[k].rem_v - dsh;
      if (k >= stp_pkg::GST) nx.gq = {dv_q[k].gq[stp_pkg::GQW-2:0], bg};
      if (bg) nx.grem = dv_q[k].grem - gdsh;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_vld_q[k+1] <= 1'b0;
      end else if (adv) begin
        dv_vld_q[k+1] <= dv_vld_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) dv_q[k+1] <= nx;
    end
  end

  assign fin = dv_q[stp_pkg::DVS];

  always_comb begin
    if (fin.sat_u) u_c = fin.neg_u ? 16'sh8000 : 16'sh7fff;
    else u_c = fin.neg_u ? -$signed({1'b0, fin.q_u}) : $signed({1'b0, fin.q_u});
    if (fin.sat_v) v_c = fin.neg_v ? 16'sh8000 : 16'sh7fff;
    else v_c = fin.neg_v ? -$signed({1'b0, fin.q_v}) : $signed({1'b0, fin.q_v});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= dv_vld_q[stp_pkg::DVS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      pix_o.pixel_u    <= u_c;
      pix_o.pixel_v    <= v_c;
      pix_o.gray_level <= fin.gsat ? 8'd255 : fin.gq;
      pix_o.on_screen  <= !u_c[15] && !v_c[15] &&
                          ({1'b0, u_c[14:0]} < {3'b000, cfg_i.vis_width}) &&
                          ({1'b0, v_c[14:0]} < {3'b000, cfg_i.vis_height});
      pix_o.new_depth  <= fin.nd;
      pix_o.last_point <= fin.last;
    end
  end

  assign pix_o.valid = out_vld_q;

endmodule

// ----- design/starfield_tail_projector.sv -----
`timescale 1ns / 1ps
// Starfield tail projector. Each star word produces TAIL_POINTS pixel words, the last one
// flagged by last_point. The back end emits one pixel per clock while the output does not
// stall, and loads the next star from the queue only once it is idle after the last pixel
// of a star. The front end works through each star in turn (depth step, then the
// quotient and remainder of the tail spacing and the gray divisor) and runs ahead of the
// back end through a two-entry queue. The first pixel of a star passes through the front
// end, the load into the back end and a 19-stage projection and division pipeline. An
// output stall freezes the back end pipeline, though an idle back end may still load
// a star from the queue; the front end keeps accepting until the queue is full.
// Registers may be written only while the block is idle.
module starfield_tail_projector #(
  parameter int unsigned TAIL_POINTS = 30
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  stp_star_if.sink    star_i,
  stp_pix_if.source   pix_o
);

  stp_pkg::cfg_t  cfg_q;
  stp_pkg::star_t push_item, pop_item;
  logic           push, full, pop, empty;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.depth_rate   <= 16'd8389;
      cfg_q.focal_length <= 12'd240;
      cfg_q.center_x     <= 12'd320;
      cfg_q.center_y     <= 12'd240;
      cfg_q.vis_width    <= 13'd640;
      cfg_q.vis_height   <= 13'd480;
    end else if (cfg_we_i) begin
      case (stp_pkg::cfg_idx_e'(cfg_idx_i))
        stp_pkg::CFG_DEPTH_RATE:   cfg_q.depth_rate   <= cfg_data_i;
        stp_pkg::CFG_FOCAL_LENGTH: cfg_q.focal_length <= cfg_data_i[11:0];
        stp_pkg::CFG_CENTER_X:     cfg_q.center_x     <= cfg_data_i[11:0];
        stp_pkg::CFG_CENTER_Y:     cfg_q.center_y     <= cfg_data_i[11:0];
        stp_pkg::CFG_VIS_WIDTH:    cfg_q.vis_width    <= cfg_data_i[12:0];
        stp_pkg::CFG_VIS_HEIGHT:   cfg_q.vis_height   <= cfg_data_i[12:0];
        default: ;
      endcase
    end
  end

  stp_front #(.TAIL_POINTS(TAIL_POINTS)) u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_q),
    .star_i (star_i),
    .item_o (push_item),
    .push_o (push),
    .full_i (full)
  );

  stp_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (push_item),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .item_o  (pop_item)
  );

  stp_back #(.TAIL_POINTS(TAIL_POINTS)) u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_q),
    .item_i  (pop_item),
    .empty_i (empty),
    .pop_o   (pop),
    .pix_o   (pix_o)
  );

endmodule

// ----- design/stp_checker.sv -----
`timescale 1ns / 1ps
module stp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        pix_valid_i,
  input logic        pix_ready_i,
  input logic [15:0] pix_u_i,
  input logic [15:0] pix_v_i,
  input logic [7:0]  pix_gray_i,
  input logic [16:0] pix_depth_i,
  input logic        pix_last_i
);

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pix_valid_i |-> (pix_depth_i != 17'd0) && (pix_depth_i <= 17'd65536))
    else $error("new depth out of range");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pix_valid_i && !pix_ready_i |=> pix_valid_i && $stable(pix_u_i) &&
      $stable(pix_v_i) && $stable(pix_gray_i) && $stable(pix_last_i))
    else $error("stalled pixel word changed");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pix_valid_i && pix_ready_i && !pix_last_i |=>
      !pix_valid_i || (pix_depth_i == $past(pix_depth_i)))
    else $error("tail pixels of one star differ in depth");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pix_valid_i && pix_ready_i && !pix_last_i |=>
      !pix_valid_i || (pix_gray_i >= $past(pix_gray_i)))
    else $error("gray ramp decreased within a tail");

endmodule

bind starfield_tail_projector stp_checker u_stp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .pix_valid_i (pix_o.valid),
  .pix_ready_i (pix_o.ready),
  .pix_u_i     (pix_o.pixel_u),
  .pix_v_i     (pix_o.pixel_v),
  .pix_gray_i  (pix_o.gray_level),
  .pix_depth_i (pix_o.new_depth),
  .pix_last_i  (pix_o.last_point)
);
